### sv/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared codes, constants and controller/datapath interface types of the
// k-nearest-neighbor top-k selector.
// ----------------------------------------------------------------------------
package knn_pkg;

   localparam int ID_BITS       = 32;
   localparam int FUNC_BITS     = 2;
   localparam int K_BITS        = 5;
   localparam int DIM_BITS      = 2;
   localparam int DRAIN_LIMIT   = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_OFFER = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_DRAIN = 2'd2;

   localparam logic [DIM_BITS-1:0] DIM_3D    = 2'd3;
   localparam logic [DIM_BITS-1:0] DIM_RESET = 2'd2;
   localparam logic [K_BITS-1:0]   K_RESET   = 5'd1;

   localparam logic REG_K_COUNT    = 1'b0;
   localparam logic REG_DIMENSIONS = 1'b1;

   typedef struct packed {
      logic capture;
      logic start;
      logic scan_init;
      logic scan_run;
      logic commit;
      logic drain_read;
      logic load_row;
      logic load_empty;
   } knn_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic drain_empty;
      logic drain_last;
      logic out_free;
   } knn_sts_type;

endpackage

### sv/knn_ram.sv
// ----------------------------------------------------------------------------
// knn_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module knn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer of the top-k selector: takes one transaction at a time and steps
// the datapath through distance, slot scan, commit and drain.
// ----------------------------------------------------------------------------
module knn_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [knn_pkg::FUNC_BITS-1:0]   req_func,
   output logic                            req_ready,
   input  knn_pkg::knn_sts_type            sts,
   output knn_pkg::knn_cmd_type            cmd
);
   import knn_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST1,
      ST_DIST2,
      ST_DIST3,
      ST_SCAN,
      ST_COMMIT,
      ST_DRAIN_RD,
      ST_DRAIN_WAIT,
      ST_EMPTY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_func)
                  FUNC_START: cmd.start = 1'b1;
                  FUNC_OFFER: state_in = ST_DIST1;
                  FUNC_DRAIN: state_in = ST_DRAIN_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIST1: state_in = ST_DIST2;
         ST_DIST2: state_in = ST_DIST3;
         ST_DIST3: begin
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DRAIN_RD: begin
            if (sts.drain_empty) begin
               state_in = ST_EMPTY;
            end else begin
               cmd.drain_read = 1'b1;
               state_in       = ST_DRAIN_WAIT;
            end
         end
         ST_DRAIN_WAIT: begin
            if (sts.out_free) begin
               cmd.load_row = 1'b1;
               state_in     = sts.drain_last ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         ST_EMPTY: begin
            if (sts.out_free) begin
               cmd.load_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/knn_dpath.sv
// ----------------------------------------------------------------------------
// knn_dpath
// Datapath of the top-k selector: query registers, squared-distance pipeline,
// slot memory with worst / second-worst scan, commit logic and result register.
// ----------------------------------------------------------------------------
module knn_dpath #(
   parameter int MAX_K      = 16,
   parameter int COORD_BITS = 16,
   localparam int DIST_BITS = 2 * COORD_BITS + 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  knn_pkg::knn_cmd_type               cmd,
   output knn_pkg::knn_sts_type               sts,
   input  logic signed [COORD_BITS-1:0]       req_coord_x,
   input  logic signed [COORD_BITS-1:0]       req_coord_y,
   input  logic signed [COORD_BITS-1:0]       req_coord_z,
   input  logic [knn_pkg::ID_BITS-1:0]        req_item_id,
   input  logic [knn_pkg::K_BITS-1:0]         k_count,
   input  logic [knn_pkg::DIM_BITS-1:0]       dimensions,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_accepted,
   output logic                               rsp_bound_valid,
   output logic [DIST_BITS-1:0]               rsp_bound_sq_dist,
   output logic                               rsp_row_valid,
   output logic [knn_pkg::ID_BITS-1:0]        rsp_row_query_id,
   output logic [knn_pkg::ID_BITS-1:0]        rsp_row_neighbor_id,
   output logic [DIST_BITS-1:0]               rsp_row_sq_dist,
   output logic                               rsp_last_row
);
   import knn_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int FILL_BITS = $clog2(MAX_K + 1);
   localparam int ADDR_BITS = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int ROW_BITS  = ID_BITS + DIST_BITS;

   function automatic logic ranks_before(input logic [DIST_BITS-1:0] da,
                                         input logic [ID_BITS-1:0]   ia,
                                         input logic [DIST_BITS-1:0] db,
                                         input logic [ID_BITS-1:0]   ib);
      return (da != db) ? (da < db) : (ia < ib);
   endfunction

   function automatic logic [FILL_BITS-1:0] idx_next_fill(input logic [FILL_BITS-1:0] f);
      return f + FILL_BITS'(1);
   endfunction

   // item and query
   logic signed [COORD_BITS-1:0] item_x_ff, item_y_ff, item_z_ff;
   logic [ID_BITS-1:0]           item_id_ff;
   logic signed [COORD_BITS-1:0] query_x_ff, query_y_ff, query_z_ff;
   logic [ID_BITS-1:0]           query_id_ff;

   // distance pipeline
   logic signed [DIFF_BITS-1:0]   diff_x_ff, diff_y_ff, diff_z_ff;
   logic signed [DIFF_BITS-1:0]   diff_x_in, diff_y_in, diff_z_in;
   logic signed [2*DIFF_BITS-1:0] prod_x, prod_y, prod_z;
   logic [SQ_BITS-1:0]            sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_BITS-1:0]          cand_d_ff, cand_d_in;

   // list state and scan
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [FILL_BITS-1:0] idx_ff, idx_in, idx_next;
   logic                 pend_ff, pend_in;
   logic [ADDR_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic                 dup_ff, dup_in;
   logic                 w1_valid_ff, w1_valid_in;
   logic [DIST_BITS-1:0] w1_d_ff, w1_d_in;
   logic [ID_BITS-1:0]   w1_id_ff, w1_id_in;
   logic [ADDR_BITS-1:0] w1_idx_ff, w1_idx_in;
   logic                 w2_valid_ff, w2_valid_in;
   logic [DIST_BITS-1:0] w2_d_ff, w2_d_in;
   logic [ID_BITS-1:0]   w2_id_ff, w2_id_in;
   logic                 scan_issue;

   // memory port
   logic                 rd_en, wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [ROW_BITS-1:0]  rd_data, wr_data;
   logic [ID_BITS-1:0]   rd_id;
   logic [DIST_BITS-1:0] rd_d;

   // commit
   logic [FILL_BITS-1:0] k_eff, drain_n, new_fill;
   logic                 can_append, cand_before_w1, do_append, do_replace, full_new;
   logic [DIST_BITS-1:0] bound_d;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accepted_ff, rsp_bound_valid_ff, rsp_row_valid_ff, rsp_last_row_ff;
   logic [DIST_BITS-1:0] rsp_bound_sq_dist_ff, rsp_row_sq_dist_ff;
   logic [ID_BITS-1:0]   rsp_row_query_id_ff, rsp_row_neighbor_id_ff;
   logic                 out_free, out_load;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_x_ff  <= req_coord_x;
         item_y_ff  <= req_coord_y;
         item_z_ff  <= req_coord_z;
         item_id_ff <= req_item_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff  <= '0;
         query_y_ff  <= '0;
         query_z_ff  <= '0;
         query_id_ff <= '0;
      end else if (cmd.start) begin
         query_x_ff  <= req_coord_x;
         query_y_ff  <= req_coord_y;
         query_z_ff  <= req_coord_z;
         query_id_ff <= req_item_id;
      end
   end

   always_comb begin
      diff_x_in = {item_x_ff[COORD_BITS-1], item_x_ff} - {query_x_ff[COORD_BITS-1], query_x_ff};
      diff_y_in = {item_y_ff[COORD_BITS-1], item_y_ff} - {query_y_ff[COORD_BITS-1], query_y_ff};
      if (dimensions == DIM_3D) begin
         diff_z_in = {item_z_ff[COORD_BITS-1], item_z_ff}
                   - {query_z_ff[COORD_BITS-1], query_z_ff};
      end else begin
         diff_z_in = '0;
      end
      prod_x    = diff_x_ff * diff_x_ff;
      prod_y    = diff_y_ff * diff_y_ff;
      prod_z    = diff_z_ff * diff_z_ff;
      cand_d_in = DIST_BITS'(sq_x_ff) + DIST_BITS'(sq_y_ff) + DIST_BITS'(sq_z_ff);
   end

   always_ff @(posedge clock) begin
      diff_x_ff <= diff_x_in;
      diff_y_ff <= diff_y_in;
      diff_z_ff <= diff_z_in;
      sq_x_ff   <= prod_x[SQ_BITS-1:0];
      sq_y_ff   <= prod_y[SQ_BITS-1:0];
      sq_z_ff   <= prod_z[SQ_BITS-1:0];
      cand_d_ff <= cand_d_in;
   end

   assign rd_id = rd_data[ROW_BITS-1 -: ID_BITS];
   assign rd_d  = rd_data[DIST_BITS-1:0];

   always_comb begin
      if (k_count == '0) begin
         k_eff = FILL_BITS'(1);
      end else if (int'(k_count) > MAX_K) begin
         k_eff = FILL_BITS'(MAX_K);
      end else begin
         k_eff = FILL_BITS'(k_count);
      end
      drain_n  = (int'(fill_ff) > DRAIN_LIMIT) ? FILL_BITS'(DRAIN_LIMIT) : fill_ff;
      idx_next = idx_ff + FILL_BITS'(1);
   end

   // scan of held rows, one per cycle, keeping worst and second worst
   always_comb begin
      scan_issue  = cmd.scan_run && (idx_ff < fill_ff);
      rd_en       = scan_issue || cmd.drain_read;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      dup_in      = dup_ff;
      w1_valid_in = w1_valid_ff;
      w1_d_in     = w1_d_ff;
      w1_id_in    = w1_id_ff;
      w1_idx_in   = w1_idx_ff;
      w2_valid_in = w2_valid_ff;
      w2_d_in     = w2_d_ff;
      w2_id_in    = w2_id_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (scan_issue || cmd.load_row) begin
         idx_in = idx_next;
      end
      if (scan_issue) begin
         pend_idx_in = idx_ff[ADDR_BITS-1:0];
      end
      if (cmd.scan_init) begin
         pend_in     = 1'b0;
         dup_in      = 1'b0;
         w1_valid_in = 1'b0;
         w2_valid_in = 1'b0;
      end else if (cmd.scan_run) begin
         pend_in = scan_issue;
         if (pend_ff) begin
            if (rd_id == item_id_ff) begin
               dup_in = 1'b1;
            end
            if (!w1_valid_ff || ranks_before(w1_d_ff, w1_id_ff, rd_d, rd_id)) begin
               w2_valid_in = w1_valid_ff;
               w2_d_in     = w1_d_ff;
               w2_id_in    = w1_id_ff;
               w1_valid_in = 1'b1;
               w1_d_in     = rd_d;
               w1_id_in    = rd_id;
               w1_idx_in   = pend_idx_ff;
            end else if (!w2_valid_ff || ranks_before(w2_d_ff, w2_id_ff, rd_d, rd_id)) begin
               w2_valid_in = 1'b1;
               w2_d_in     = rd_d;
               w2_id_in    = rd_id;
            end
         end
      end
   end

   // insert or replace, and the bound after the update
   always_comb begin
      can_append     = fill_ff < k_eff;
      cand_before_w1 = ranks_before(cand_d_ff, item_id_ff, w1_d_ff, w1_id_ff);
      do_append      = !dup_ff && can_append;
      do_replace     = !dup_ff && !can_append && w1_valid_ff && cand_before_w1;
      new_fill       = do_append ? idx_next_fill(fill_ff) : fill_ff;
      full_new       = (new_fill >= k_eff) && (new_fill != '0);
      if (!full_new) begin
         bound_d = '0;
      end else if (do_append) begin
         bound_d = (w1_valid_ff && cand_before_w1) ? w1_d_ff : cand_d_ff;
      end else if (do_replace) begin
         bound_d = (w2_valid_ff && !ranks_before(w2_d_ff, w2_id_ff, cand_d_ff, item_id_ff))
                   ? w2_d_ff : cand_d_ff;
      end else begin
         bound_d = w1_d_ff;
      end
      fill_in = fill_ff;
      if (cmd.start) begin
         fill_in = '0;
      end else if (cmd.commit && do_append) begin
         fill_in = new_fill;
      end
      wr_en   = cmd.commit && (do_append || do_replace);
      wr_addr = do_append ? fill_ff[ADDR_BITS-1:0] : w1_idx_ff;
      wr_data = {item_id_ff, cand_d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      dup_ff      <= dup_in;
      w1_valid_ff <= w1_valid_in;
      w1_d_ff     <= w1_d_in;
      w1_id_ff    <= w1_id_in;
      w1_idx_ff   <= w1_idx_in;
      w2_valid_ff <= w2_valid_in;
      w2_d_ff     <= w2_d_in;
      w2_id_ff    <= w2_id_in;
   end

   knn_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (MAX_K)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = cmd.commit || cmd.load_row || cmd.load_empty;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.commit) begin
         rsp_accepted_ff        <= do_append || do_replace;
         rsp_bound_valid_ff     <= full_new;
         rsp_bound_sq_dist_ff   <= bound_d;
         rsp_row_valid_ff       <= 1'b0;
         rsp_row_query_id_ff    <= '0;
         rsp_row_neighbor_id_ff <= '0;
         rsp_row_sq_dist_ff     <= '0;
         rsp_last_row_ff        <= 1'b1;
      end else if (cmd.load_row) begin
         rsp_accepted_ff        <= 1'b0;
         rsp_bound_valid_ff     <= 1'b0;
         rsp_bound_sq_dist_ff   <= '0;
         rsp_row_valid_ff       <= 1'b1;
         rsp_row_query_id_ff    <= query_id_ff;
         rsp_row_neighbor_id_ff <= rd_id;
         rsp_row_sq_dist_ff     <= rd_d;
         rsp_last_row_ff        <= (idx_next == drain_n);
      end else if (cmd.load_empty) begin
         rsp_accepted_ff        <= 1'b0;
         rsp_bound_valid_ff     <= 1'b0;
         rsp_bound_sq_dist_ff   <= '0;
         rsp_row_valid_ff       <= 1'b0;
         rsp_row_query_id_ff    <= '0;
         rsp_row_neighbor_id_ff <= '0;
         rsp_row_sq_dist_ff     <= '0;
         rsp_last_row_ff        <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_bound_valid     = rsp_bound_valid_ff;
   assign rsp_bound_sq_dist   = rsp_bound_sq_dist_ff;
   assign rsp_row_valid       = rsp_row_valid_ff;
   assign rsp_row_query_id    = rsp_row_query_id_ff;
   assign rsp_row_neighbor_id = rsp_row_neighbor_id_ff;
   assign rsp_row_sq_dist     = rsp_row_sq_dist_ff;
   assign rsp_last_row        = rsp_last_row_ff;

   assign sts.scan_done   = (idx_ff == fill_ff) && !pend_ff;
   assign sts.drain_empty = (drain_n == '0);
   assign sts.drain_last  = (idx_next == drain_n);
   assign sts.out_free    = out_free;

   a_start_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (fill_ff == '0))
      else $error("list not emptied by start");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_append) |=> (fill_ff == $past(fill_ff) + FILL_BITS'(1)))
      else $error("append did not advance the fill count");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten while pending");

   a_worst_held: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && w1_valid_ff) |-> (FILL_BITS'(w1_idx_ff) < fill_ff))
      else $error("worst slot outside the held rows");

   a_bound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bound_valid_ff) |-> (rsp_bound_sq_dist_ff == '0))
      else $error("bound reported without a full list");

endmodule

### sv/knn_topk_selector.sv
// ----------------------------------------------------------------------------
// knn_topk_selector
// Keeps the k nearest candidates of one query point by exact squared distance.
// An offer passes from the accepting cycle through three distance stages
// (difference, square, sum), a scan of the held rows through the read port of
// the slot memory at one row per cycle with the registered read of each row
// and a check for the scan end, and a commit that writes the slot and forms
// the bound. A drain reads each row through the registered read of the slot
// memory before it is loaded into the output register, and an empty list
// gives one result. Results wait in an output register, so the next
// transaction is taken while a result is still pending; the commit, each
// drained row and the empty result wait for as long as an earlier result is
// not taken. k_count and dimensions are written through the csr port; the
// user must write them only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module knn_topk_selector #(
   parameter int MAX_K      = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [knn_pkg::FUNC_BITS-1:0]        req_func,
   input  logic signed [COORD_BITS-1:0]         req_coord_x,
   input  logic signed [COORD_BITS-1:0]         req_coord_y,
   input  logic signed [COORD_BITS-1:0]         req_coord_z,
   input  logic [knn_pkg::ID_BITS-1:0]          req_item_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_accepted,
   output logic                                 rsp_bound_valid,
   output logic [2*COORD_BITS+1:0]              rsp_bound_sq_dist,
   output logic                                 rsp_row_valid,
   output logic [knn_pkg::ID_BITS-1:0]          rsp_row_query_id,
   output logic [knn_pkg::ID_BITS-1:0]          rsp_row_neighbor_id,
   output logic [2*COORD_BITS+1:0]              rsp_row_sq_dist,
   output logic                                 rsp_last_row,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [knn_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [knn_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [knn_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import knn_pkg::*;

   logic [K_BITS-1:0]   k_count_ff;
   logic [DIM_BITS-1:0] dimensions_ff;
   logic                csr_write;
   logic                reg_sel;
   knn_cmd_type         cmd;
   knn_sts_type         sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff    <= K_RESET;
         dimensions_ff <= DIM_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_K_COUNT:    k_count_ff    <= csr_pwdata[K_BITS-1:0];
            REG_DIMENSIONS: dimensions_ff <= csr_pwdata[DIM_BITS-1:0];
            default:        k_count_ff    <= k_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_K_COUNT:    csr_prdata = CSR_DATA_BITS'(k_count_ff);
         REG_DIMENSIONS: csr_prdata = CSR_DATA_BITS'(dimensions_ff);
         default:        csr_prdata = '0;
      endcase
   end

   knn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   knn_dpath #(
      .MAX_K      (MAX_K),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .req_coord_z         (req_coord_z),
      .req_item_id         (req_item_id),
      .k_count             (k_count_ff),
      .dimensions          (dimensions_ff),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_bound_valid     (rsp_bound_valid),
      .rsp_bound_sq_dist   (rsp_bound_sq_dist),
      .rsp_row_valid       (rsp_row_valid),
      .rsp_row_query_id    (rsp_row_query_id),
      .rsp_row_neighbor_id (rsp_row_neighbor_id),
      .rsp_row_sq_dist     (rsp_row_sq_dist),
      .rsp_last_row        (rsp_last_row)
   );

endmodule
